// ----- rtl/core/slfc_pkg.sv -----
// slfc_pkg: shared types and constants of the six-point line fit block.
// Used by every module under rtl/core except slfc_div; depends on nothing.
`default_nettype none

package slfc_pkg;

  localparam int NUM_PTS   = 6;
  // quotient bits of the slope/intercept dividers and of the distance dividers
  localparam int FIT_QW    = 32;
  localparam int LANE_QW   = 63;
  // pipeline depth of each part, in register stages
  localparam int FIT_LAT   = 8 + FIT_QW;
  localparam int LANE_LAT  = 7 + LANE_QW;
  localparam int MERGE_LAT = 3;
  localparam int PIPE_LAT  = FIT_LAT + LANE_LAT + MERGE_LAT;

  localparam logic [31:0] THR_RESET = 32'd6400;
  localparam logic [62:0] SUM_MAX   = '1;

  typedef struct packed {
    logic signed [15:0] x_0;
    logic signed [15:0] x_1;
    logic signed [15:0] x_2;
    logic signed [15:0] x_3;
    logic signed [15:0] x_4;
    logic signed [15:0] x_5;
    logic signed [15:0] y_0;
    logic signed [15:0] y_1;
    logic signed [15:0] y_2;
    logic signed [15:0] y_3;
    logic signed [15:0] y_4;
    logic signed [15:0] y_5;
  } points_t;

  typedef struct packed {
    logic signed [30:0] slope;
    logic signed [31:0] intercept;
    logic        [62:0] distance_sum;
  } line_t;

  // fitted line handed to the distance lanes
  typedef struct packed {
    logic signed [30:0] slope;
    logic signed [31:0] intercept;
    logic        [60:0] denom;
  } fit_t;

endpackage

`default_nettype wire

// ----- rtl/core/slfc_div.sv -----
// slfc_div: pipelined restoring divider, one quotient bit per stage.
// Carries a sideband word along; uses no package items.
`default_nettype none

module slfc_div #(
  parameter int NW  = 55,
  parameter int DW  = 37,
  parameter int QW  = 32,
  parameter int SBW = 2
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [NW-1:0]  num,
  input  wire logic [DW-1:0]  den,
  input  wire logic [SBW-1:0] sb_in,
  output logic      [QW-1:0]  quo,
  output logic      [SBW-1:0] sb_out
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0]  rem_q [QW];
  logic [DW-1:0]  den_q [QW];
  logic [QW-1:0]  quo_q [QW];
  logic [SBW-1:0] sb_q  [QW];
  logic [NW-1:0]  rem_i [QW];
  logic [DW-1:0]  den_i [QW];
  logic [QW-1:0]  quo_i [QW];
  logic [SBW-1:0] sb_i  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [CW-1:0] trial;
    logic [CW-1:0] diff;
    logic          take;

    if (s == 0) begin : g_first
      assign rem_i[s] = num;
      assign den_i[s] = den;
      assign quo_i[s] = '0;
      assign sb_i[s]  = sb_in;
    end else begin : g_next
      assign rem_i[s] = rem_q[s-1];
      assign den_i[s] = den_q[s-1];
      assign quo_i[s] = quo_q[s-1];
      assign sb_i[s]  = sb_q[s-1];
    end

    assign trial = CW'(den_i[s]) << B;
    assign take  = CW'(rem_i[s]) >= trial;
    assign diff  = CW'(rem_i[s]) - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= take ? diff[NW-1:0] : rem_i[s];
        den_q[s] <= den_i[s];
        quo_q[s] <= quo_i[s] | (QW'(take) << B);
        sb_q[s]  <= sb_i[s];
      end
    end
  end

  assign quo    = quo_q[QW-1];
  assign sb_out = sb_q[QW-1];

endmodule

`default_nettype wire

// ----- rtl/core/slfc_fit.sv -----
// slfc_fit: least-squares sums, slope and intercept division, clamp and the
// shared distance denominator. Uses slfc_pkg and slfc_div.
`default_nettype none

module slfc_fit (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire slfc_pkg::points_t points,
  output slfc_pkg::fit_t         fit,
  output slfc_pkg::points_t      pts
);

  localparam int QW = slfc_pkg::FIT_QW;
  localparam logic signed [30:0] K_CLAMP = 31'sd655360000;

  slfc_pkg::points_t p1, p2, p3, p4, p5, p6, p8, p9;

  logic signed [15:0] x1 [slfc_pkg::NUM_PTS];
  logic signed [15:0] y1 [slfc_pkg::NUM_PTS];
  logic signed [15:0] x2 [slfc_pkg::NUM_PTS];
  logic signed [15:0] y2 [slfc_pkg::NUM_PTS];

  logic signed [31:0] sq2 [slfc_pkg::NUM_PTS];
  logic signed [31:0] cp2 [slfc_pkg::NUM_PTS];

  logic signed [18:0] sx3, sy3, sx_c, sy_c;
  logic signed [34:0] sxx3, sxy3, sxx_c, sxy_c;

  logic signed [37:0] sxy6, sxsy, sxx6, sxsx;
  logic signed [53:0] sxxsy, sxysx;

  logic signed [38:0] n5, d5;
  logic signed [54:0] m5;
  logic signed [38:0] n_abs;
  logic signed [54:0] m_abs;

  logic        [37:0] absn6;
  logic        [36:0] d6;
  logic        [50:0] dlim6;
  logic        [54:0] kdiv6, bdiv6;
  logic               nneg6, mneg6, dzero6;
  logic               clamp7, bovf7;

  logic [QW-1:0]      qk, qb;
  logic [193:0]       sbk;
  logic [1:0]         sbb;
  logic               clamp_d, nneg_d, bovf_d, mneg_d;

  logic signed [30:0] k_next, k8, k9;
  logic signed [31:0] b_next, b8, b9;
  logic signed [31:0] bx0;
  logic        [29:0] kk;
  logic        [60:0] denom9;

  assign x1 = '{p1.x_0, p1.x_1, p1.x_2, p1.x_3, p1.x_4, p1.x_5};
  assign y1 = '{p1.y_0, p1.y_1, p1.y_2, p1.y_3, p1.y_4, p1.y_5};
  assign x2 = '{p2.x_0, p2.x_1, p2.x_2, p2.x_3, p2.x_4, p2.x_5};
  assign y2 = '{p2.y_0, p2.y_1, p2.y_2, p2.y_3, p2.y_4, p2.y_5};

  always_comb begin
    sx_c  = '0;
    sy_c  = '0;
    sxx_c = '0;
    sxy_c = '0;
    for (int i = 0; i < slfc_pkg::NUM_PTS; i++) begin
      sx_c  = sx_c + 19'(x2[i]);
      sy_c  = sy_c + 19'(y2[i]);
      sxx_c = sxx_c + 35'(sq2[i]);
      sxy_c = sxy_c + 35'(cp2[i]);
    end
  end

  always_comb begin
    n_abs  = n5[38] ? -n5 : n5;
    m_abs  = m5[54] ? -m5 : m5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // point products
      p1 <= points;
      for (int i = 0; i < slfc_pkg::NUM_PTS; i++) begin
        sq2[i] <= x1[i] * x1[i];
        cp2[i] <= x1[i] * y1[i];
      end
      p2 <= p1;
      // sums
      sx3  <= sx_c;
      sy3  <= sy_c;
      sxx3 <= sxx_c;
      sxy3 <= sxy_c;
      p3   <= p2;
      // cross products of the sums
      sxy6  <= 38'(sxy3) * 38'sd6;
      sxx6  <= 38'(sxx3) * 38'sd6;
      sxsy  <= 38'(sx3) * 38'(sy3);
      sxsx  <= 38'(sx3) * 38'(sx3);
      sxxsy <= 54'(sxx3) * 54'(sy3);
      sxysx <= 54'(sxy3) * 54'(sx3);
      p4    <= p3;
      // numerators and spread
      n5 <= 39'(sxy6) - 39'(sxsy);
      d5 <= 39'(sxx6) - 39'(sxsx);
      m5 <= 55'(sxxsy) - 55'(sxysx);
      p5 <= p4;
      // magnitudes with rounding half added
      nneg6  <= n5[38];
      mneg6  <= m5[54];
      absn6  <= n_abs[37:0];
      d6     <= d5[36:0];
      dzero6 <= (d5 == '0);
      dlim6  <= 51'(d5[36:0]) * 51'd10000;
      kdiv6  <= 55'({n_abs[37:0], 16'b0}) + 55'(d5[36:1]);
      bdiv6  <= 55'(m_abs[53:0]) + 55'(d5[36:1]);
      p6     <= p5;
    end
  end

  assign clamp7 = dzero6 || (51'(absn6) > dlim6);
  assign bovf7  = 69'(bdiv6) >= {d6, 32'b0};

  slfc_div #(.NW(55), .DW(37), .QW(QW), .SBW(194)) u_div_k (
    .clk    (clk),
    .en     (en),
    .num    (kdiv6),
    .den    (d6),
    .sb_in  ({clamp7, nneg6, p6}),
    .quo    (qk),
    .sb_out (sbk)
  );

  slfc_div #(.NW(55), .DW(37), .QW(QW), .SBW(2)) u_div_b (
    .clk    (clk),
    .en     (en),
    .num    (bdiv6),
    .den    (d6),
    .sb_in  ({bovf7, mneg6}),
    .quo    (qb),
    .sb_out (sbb)
  );

  assign clamp_d = sbk[193];
  assign nneg_d  = sbk[192];
  assign bovf_d  = sbb[1];
  assign mneg_d  = sbb[0];
  assign bx0     = 32'($signed(sbk[191 -: 16])) * 32'sd10000;

  always_comb begin
    if (clamp_d) begin
      k_next = nneg_d ? -K_CLAMP : K_CLAMP;
      b_next = nneg_d ? bx0 : -bx0;
    end else begin
      k_next = nneg_d ? -$signed(qk[30:0]) : $signed(qk[30:0]);
      priority if (bovf_d) begin
        b_next = mneg_d ? 32'sh80000000 : 32'sh7fffffff;
      end else if (!mneg_d) begin
        b_next = (qb > 32'h7fffffff) ? 32'sh7fffffff : $signed(qb);
      end else begin
        b_next = (qb > 32'h80000000) ? 32'sh80000000 : $signed(32'(0 - qb));
      end
    end
  end

  always_comb begin
    kk = k8[30] ? 30'(-k8) : k8[29:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k8     <= k_next;
      b8     <= b_next;
      p8     <= sbk[191:0];
      k9     <= k8;
      b9     <= b8;
      p9     <= p8;
      denom9 <= (61'(kk) * 61'(kk)) + (61'(1) << 32);
    end
  end

  assign fit.slope     = k9;
  assign fit.intercept = b9;
  assign fit.denom     = denom9;
  assign pts           = p9;

endmodule

`default_nettype wire

// ----- rtl/core/slfc_lane.sv -----
// slfc_lane: squared perpendicular distance of one point to the fitted line,
// with the threshold penalty. Uses slfc_pkg and slfc_div.
`default_nettype none

module slfc_lane (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire slfc_pkg::fit_t     fit,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic        [31:0] threshold,
  output logic             [62:0] term
);

  logic signed [46:0] p0;
  logic signed [32:0] t0;
  logic        [60:0] den0, den1, den2, den3, den4;
  logic signed [49:0] r_c, rabs_c;
  logic        [47:0] ar1;
  logic        [47:0] hh2, hl2, ll2;
  logic        [95:0] sq_c;
  logic        [96:0] dvd3, dvd4;
  logic               ovf4;
  logic        [62:0] q;
  logic               ovf_d;
  logic        [62:0] eta_c, eta1;
  logic               gt1, big1;
  logic        [63:0] prod1;

  always_comb begin
    r_c    = 50'(p0) + (50'(t0) <<< 16);
    rabs_c = r_c[49] ? -r_c : r_c;
    sq_c   = (96'(hh2) << 48) + (96'(hl2) << 25) + 96'(ll2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0   <= fit.slope * x;
      t0   <= 33'(fit.intercept) - 33'(y);
      den0 <= fit.denom;
      // |r| stays below 2^48
      ar1  <= rabs_c[47:0];
      den1 <= den0;
      // square split into 24-bit halves
      hh2  <= ar1[47:24] * ar1[47:24];
      hl2  <= ar1[47:24] * ar1[23:0];
      ll2  <= ar1[23:0] * ar1[23:0];
      den2 <= den1;
      dvd3 <= 97'(sq_c) + 97'(den2[60:1]);
      den3 <= den2;
      ovf4 <= 124'(dvd3) >= {den3, 63'b0};
      dvd4 <= dvd3;
      den4 <= den3;
    end
  end

  slfc_div #(.NW(97), .DW(61), .QW(slfc_pkg::LANE_QW), .SBW(1)) u_div (
    .clk    (clk),
    .en     (en),
    .num    (dvd4),
    .den    (den4),
    .sb_in  (ovf4),
    .quo    (q),
    .sb_out (ovf_d)
  );

  assign eta_c = ovf_d ? slfc_pkg::SUM_MAX : q;

  always_ff @(posedge clk) begin
    if (en) begin
      eta1  <= eta_c;
      gt1   <= eta_c > 63'(threshold);
      // above this the penalized term saturates
      big1  <= eta_c > 63'd922337203;
      prod1 <= 64'(eta_c[29:0]) * 64'd10000000000;
      term  <= !gt1 ? eta1 : (big1 ? slfc_pkg::SUM_MAX : prod1[62:0]);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slfc_merge.sv -----
// slfc_merge: registered saturating adder tree over the six lane terms.
// Uses slfc_pkg.
`default_nettype none

module slfc_merge (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [62:0] terms [slfc_pkg::NUM_PTS],
  output logic      [62:0] sum
);

  logic [62:0] s1 [3];
  logic [62:0] s2a, s2b;

  function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [62:0] b);
    logic [63:0] s;
    s = 64'(a) + 64'(b);
    return s[63] ? slfc_pkg::SUM_MAX : s[62:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      s1[0] <= sat_add(terms[0], terms[1]);
      s1[1] <= sat_add(terms[2], terms[3]);
      s1[2] <= sat_add(terms[4], terms[5]);
      s2a   <= sat_add(s1[0], s1[1]);
      s2b   <= s1[2];
      sum   <= sat_add(s2a, s2b);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/six_point_line_fit_chi2.sv -----
// six_point_line_fit_chi2: top level, pipeline valid chain, threshold
// register and output buffer. Uses slfc_pkg, slfc_fit, slfc_lane, slfc_merge.
`default_nettype none

// Fits a straight line to six points per item and scores it. One item is
// taken per clock cycle while point_stall is low; each result passes through
// the fit with its 32-step slope and intercept dividers, the six distance
// lanes, each with a 63-step divider, and the summing tree, then through the
// two-entry output buffer. The whole pipeline advances together and stops
// only while that buffer holds two results; point_stall is high exactly
// then. The threshold register may be written only while no item is in
// flight.

module six_point_line_fit_chi2 (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              point_valid,
  output logic                   point_stall,
  input  wire slfc_pkg::points_t points,
  output logic                   line_valid,
  input  wire logic              line_stall,
  output slfc_pkg::line_t        line,
  input  wire logic              thr_we,
  input  wire logic [31:0]       thr_wdata
);

  localparam int LAT   = slfc_pkg::PIPE_LAT;
  localparam int KBLAT = slfc_pkg::LANE_LAT + slfc_pkg::MERGE_LAT;

  logic [31:0]       threshold;
  logic [LAT-1:0]    vld;
  logic              en;
  logic [1:0]        cnt;
  logic              push, pop;

  slfc_pkg::fit_t    fit;
  slfc_pkg::points_t fpts;
  slfc_pkg::line_t   res, head, tail;

  logic signed [15:0] lx [slfc_pkg::NUM_PTS];
  logic signed [15:0] ly [slfc_pkg::NUM_PTS];
  logic        [62:0] terms [slfc_pkg::NUM_PTS];
  logic        [62:0] sum;
  logic        [62:0] kb [KBLAT];

  assign en          = (cnt != 2'd2);
  assign point_stall = !en;
  assign push        = en && vld[LAT-1];
  assign pop         = line_valid && !line_stall;
  assign line_valid  = (cnt != 2'd0);
  assign line        = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= slfc_pkg::THR_RESET;
    end else if (thr_we) begin
      threshold <= thr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], point_valid};
    end
  end

  slfc_fit u_fit (
    .clk    (clk),
    .en     (en),
    .points (points),
    .fit    (fit),
    .pts    (fpts)
  );

  assign lx = '{fpts.x_0, fpts.x_1, fpts.x_2, fpts.x_3, fpts.x_4, fpts.x_5};
  assign ly = '{fpts.y_0, fpts.y_1, fpts.y_2, fpts.y_3, fpts.y_4, fpts.y_5};

  for (genvar i = 0; i < slfc_pkg::NUM_PTS; i++) begin : g_lane
    slfc_lane u_lane (
      .clk       (clk),
      .en        (en),
      .fit       (fit),
      .x         (lx[i]),
      .y         (ly[i]),
      .threshold (threshold),
      .term      (terms[i])
    );
  end

  slfc_merge u_merge (
    .clk   (clk),
    .en    (en),
    .terms (terms),
    .sum   (sum)
  );

  // slope and intercept ride alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      kb[0] <= {fit.slope, fit.intercept};
      for (int i = 1; i < KBLAT; i++) begin
        kb[i] <= kb[i-1];
      end
    end
  end

  assign res.slope        = kb[KBLAT-1][62:32];
  assign res.intercept    = kb[KBLAT-1][31:0];
  assign res.distance_sum = sum;

  // two-entry output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          head <= res;
        end else begin
          tail <= res;
        end
      end
      2'b01:   head <= tail;
      2'b11:   head <= res;
      default: head <= head;
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer count out of range");

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop) |=> cnt == 2'd2)
    else $error("output buffer lost an item");

  a_frozen_pipe: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");

  a_slope_range: assert property (@(posedge clk) disable iff (rst)
    line_valid |-> (line.slope <= 31'sd655360000 && line.slope >= -31'sd655360000))
    else $error("slope outside clamp range");
`endif

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for six_point_line_fit_chi2 (line fit with
// perpendicular distance score). Depends on slfc_pkg and the block's RTL only.
module tb_top;

  localparam int LATENCY   = slfc_pkg::PIPE_LAT + 4;
  localparam int CYCLE_MAX = 400000;
  localparam logic [63:0] PENALTY_F = 64'd10000000000;
  localparam logic [63:0] SUM_MAX_F = 64'h7FFF_FFFF_FFFF_FFFF;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              point_valid = 1'b0;
  logic              point_stall;
  slfc_pkg::points_t points = '0;
  logic              line_valid;
  logic              line_stall = 1'b0;
  slfc_pkg::line_t   line;
  logic              thr_we = 1'b0;
  logic [31:0]       thr_wdata = '0;

  logic [31:0]       thr_model;
  slfc_pkg::line_t   fits_due[$];
  int          errors = 0;
  int          cycles = 0;
  int          idle_pct = 36;
  int          n_sent = 0;
  int          n_checked = 0;

  six_point_line_fit_chi2 DUT (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall), .points(points),
    .line_valid(line_valid), .line_stall(line_stall), .line(line),
    .thr_we(thr_we), .thr_wdata(thr_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // round half away from zero, den > 0
  function automatic longint div_away(longint num, longint den);
    longint a;
    longint q;
    a = (num < 0) ? -num : num;
    q = (a + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic slfc_pkg::line_t fit_line(slfc_pkg::points_t p);
    longint xs[6], ys[6];
    longint sx, sy, sxx, sxy, nm, dn, k, b, kc, absn, r;
    logic [127:0] ar2, q;
    logic [63:0] denom, eta, total;
    slfc_pkg::line_t o;
    sx = 0; sy = 0; sxx = 0; sxy = 0; total = 0;
    xs = '{p.x_0, p.x_1, p.x_2, p.x_3, p.x_4, p.x_5};
    ys = '{p.y_0, p.y_1, p.y_2, p.y_3, p.y_4, p.y_5};
    for (int i = 0; i < 6; i++) begin
      sx += xs[i]; sy += ys[i]; sxx += xs[i] * xs[i]; sxy += xs[i] * ys[i];
    end
    nm = 6 * sxy - sx * sy;
    dn = 6 * sxx - sx * sx;
    absn = (nm < 0) ? -nm : nm;
    if (dn <= 0 || absn > dn * 10000) begin
      kc = (nm < 0) ? -10000 : 10000;
      k = kc * 65536;
      b = -kc * xs[0];
    end else begin
      k = div_away(nm * 65536, dn);
      b = div_away(sxx * sy - sxy * sx, dn);
      if (b > 64'sd2147483647) b = 64'sd2147483647;
      if (b < -64'sd2147483648) b = -64'sd2147483648;
    end
    denom = k * k + (64'd1 << 32);
    for (int i = 0; i < 6; i++) begin
      r = k * xs[i] + (b - ys[i]) * 65536;
      if (r < 0) r = -r;
      ar2 = 128'(r) * 128'(r);
      q = (ar2 + 128'(denom / 2)) / 128'(denom);
      eta = (q > 128'(SUM_MAX_F)) ? SUM_MAX_F : q[63:0];
      if (eta > 64'(thr_model))
        eta = (eta > SUM_MAX_F / PENALTY_F) ? SUM_MAX_F : eta * PENALTY_F;
      total = (eta > SUM_MAX_F - total) ? SUM_MAX_F : total + eta;
    end
    o.slope = k[30:0];
    o.intercept = b[31:0];
    o.distance_sum = total[62:0];
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_checked);
  endtask

  // result side: random stall and checking
  always @(posedge clk) begin
    if (!rst) begin
      if (line_valid && !line_stall) begin
        if (fits_due.size() == 0) begin
          report("unexpected item", 64'(line.distance_sum), 64'd0);
        end else begin
          slfc_pkg::line_t w;
          w = fits_due.pop_front();
          if (line.slope !== w.slope)
            report("slope", 64'(line.slope), 64'(w.slope));
          if (line.intercept !== w.intercept)
            report("intercept", 64'(line.intercept), 64'(w.intercept));
          if (line.distance_sum !== w.distance_sum)
            report("distance_sum", 64'(line.distance_sum), 64'(w.distance_sum));
        end
        n_checked++;
      end
      line_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // valid stays high between back-to-back items; idling and drain drop it
  task automatic send_points(slfc_pkg::points_t p);
    while ($urandom_range(99) < idle_pct) begin
      point_valid <= 1'b0;
      @(posedge clk);
    end
    point_valid <= 1'b1;
    points <= p;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    fits_due.push_back(fit_line(p));
    n_sent++;
  endtask

  task automatic drain();
    point_valid <= 1'b0;
    while (fits_due.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] v);
    drain();
    thr_we <= 1'b1;
    thr_wdata <= v;
    @(posedge clk);
    thr_we <= 1'b0;
    thr_model = v;
  endtask

  function automatic slfc_pkg::points_t line_points(bit noisy);
    slfc_pkg::points_t p;
    int k, b, span;
    logic signed [15:0] xv, yv;
    span = $urandom_range(3) == 0 ? 32767 : $urandom_range(4000, 10);
    k = $urandom_range(8) - 4;
    b = $urandom_range(2000) - 1000;
    for (int i = 0; i < 6; i++) begin
      xv = 16'($urandom_range(2 * span) - span);
      yv = 16'(k * xv + b + (noisy ? $urandom_range(64) - 32 : 0));
      p[16 * (11 - i) +: 16] = xv;
      p[16 * (5 - i) +: 16] = yv;
    end
    return p;
  endfunction

  task automatic test_directed();
    slfc_pkg::points_t p;
    send_points('0);
    send_points({{6{16'sh7FFF}}, {6{16'sh8000}}});
    send_points({{6{16'sh8000}}, {6{16'sh7FFF}}});
    send_points({16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    // vertical line, slope sign from the numerator
    send_points({{6{16'sd5}}, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5, 16'sd6});
    send_points({{6{16'sd5}}, {6{16'sd9}}});
    // steep but finite slope, clamp on either side
    send_points({16'sd0, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd1,
                 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    send_points({16'sd0, 16'sd1, 16'sd0, 16'sd1, 16'sd0, 16'sd1,
                 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000});
    // steep slope that clamps; intercept set from the first x
    send_points({16'sd1, 16'sd2, 16'sd1, 16'sd2, 16'sd1, 16'sd2,
                 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF} ^
                {96'd0, 96'd0});
    send_points({16'sd10, 16'sd20, 16'sd30, 16'sd40, 16'sd50, 16'sd60,
                 16'sd10, 16'sd20, 16'sd30, 16'sd40, 16'sd50, 16'sd60});
    for (int i = 0; i < 8; i++) begin
      p = line_points(1);
      send_points(p);
    end
    send_points({12{16'hFFFF}});
    send_points({12{16'h5555}});
    send_points({12{16'hAAAA}});
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 7) send_points(line_points($urandom_range(1)));
      else send_points({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end
  endtask

  initial begin
    thr_model = slfc_pkg::THR_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_threshold(32'd0);
    test_directed();
    write_threshold(32'hFFFF_FFFF);
    test_directed();
    test_random(150);
    write_threshold(32'd64);
    test_random(150);
    // wait for every result before going on
    drain();
    idle_pct = 0;
    test_random(150);
    idle_pct = 36;
    write_threshold(32'd6400);
    test_random(150);
    write_threshold($urandom);
    test_random(100);
    drain();
    $display("sent %0d point sets over five threshold settings, checked %0d fits",
             n_sent, n_checked);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
